>>> rtl/core/lcd_pkg.sv
// Shared types, codes and the mode encoder for the lane change decision block.
// No dependencies; lane_change_decision_fsm and lcd_next import this package.
package lcd_pkg;

  // One-hot mode register codes.
  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_DANGER = 4'b0010,
    MODE_LANE   = 4'b0100,
    MODE_COOL   = 4'b1000
  } mode_t;

  // Mode numbers as they appear on the result channel.
  localparam logic [1:0] CODE_NORMAL = 2'd0;
  localparam logic [1:0] CODE_DANGER = 2'd1;
  localparam logic [1:0] CODE_LANE   = 2'd2;
  localparam logic [1:0] CODE_COOL   = 2'd3;

  localparam logic [1:0] LANE_LEFT   = 2'd0;
  localparam logic [1:0] LANE_MIDDLE = 2'd1;
  localparam logic [1:0] LANE_RIGHT  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ACCEL_STEP = 2'd0;
  localparam logic [1:0] REG_DECEL_STEP = 2'd1;
  localparam logic [1:0] REG_MIN_SPEED  = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [11:0] ACCEL_STEP_RST = 12'd26;
  localparam logic [11:0] DECEL_STEP_RST = 12'd38;
  localparam logic [15:0] MIN_SPEED_RST  = 16'd256;

  typedef struct packed {
    logic [11:0] accel_step;
    logic [11:0] decel_step;
    logic [15:0] min_speed;
  } cfg_t;

  typedef struct packed {
    logic        danger_lane0;
    logic        danger_lane1;
    logic        danger_lane2;
    logic        brake_ok;
    logic [31:0] now_tick;
    logic [15:0] recommended_speed;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  lane;
    logic [15:0] speed;
    logic [31:0] hold_until;
  } state_t;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    c = CODE_NORMAL;
    unique case (m)
      MODE_NORMAL: c = CODE_NORMAL;
      MODE_DANGER: c = CODE_DANGER;
      MODE_LANE:   c = CODE_LANE;
      MODE_COOL:   c = CODE_COOL;
      default:     c = CODE_NORMAL;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/lcd_in_if.sv
// Input channel of the lane change decision block: valid/ready plus one control tick.
// Standalone; no package dependency.
interface lcd_in_if;
  logic        valid;
  logic        ready;
  logic        danger_lane0;
  logic        danger_lane1;
  logic        danger_lane2;
  logic        brake_ok;
  logic [31:0] now_tick;
  logic [15:0] recommended_speed;

  modport source (
    output valid, danger_lane0, danger_lane1, danger_lane2, brake_ok, now_tick,
           recommended_speed,
    input  ready
  );
  modport sink (
    input  valid, danger_lane0, danger_lane1, danger_lane2, brake_ok, now_tick,
           recommended_speed,
    output ready
  );
endinterface

>>> rtl/core/lcd_out_if.sv
// Result channel of the lane change decision block: valid/ready plus the new state.
// Standalone; no package dependency.
interface lcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_mode;
  logic [1:0]  new_lane;
  logic [15:0] new_speed;
  logic [31:0] out_hold_until;

  modport source (
    output valid, out_mode, new_lane, new_speed, out_hold_until,
    input  ready
  );
  modport sink (
    input  valid, out_mode, new_lane, new_speed, out_hold_until,
    output ready
  );
endinterface

>>> rtl/core/lane_change_decision_fsm.sv
// Top level of the lane change decision block: input register, state, result register.
// Depends on lcd_pkg, lcd_in_if, lcd_out_if and lcd_next.
//
//   channel  | direction | carries
//   ---------+-----------+----------------------------------------------
//   item     | in        | lane danger flags, brake flag, tick, rec. speed
//   result   | out       | new mode, lane, speed and hold tick
//   cfg_*    | in        | register writes: accel, decel, min speed
//
// One item is taken every cycle unless the result stalls; an item is held in the input
// register, its new state in the result register. The rate is set by the combinational
// next-state logic in lcd_next, which reads the state left by the previous item. Reset
// clears the valid bits, the state and the registers to their defaults. While a result
// waits, the input register still takes one item and then stalls the input.
module lane_change_decision_fsm import lcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lcd_in_if.sink                item,
  lcd_out_if.source             result
);

  cfg_t   cfg;
  item_t  in_reg;
  logic   in_valid;
  state_t st;
  state_t st_next;
  state_t res_reg;
  logic   res_valid;
  logic   advance;
  logic   fire;

  assign advance    = !res_valid || result.ready;
  assign fire       = in_valid && advance;
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_step <= ACCEL_STEP_RST;
      cfg.decel_step <= DECEL_STEP_RST;
      cfg.min_speed  <= MIN_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_STEP: cfg.accel_step <= cfg_data[11:0];
        REG_DECEL_STEP: cfg.decel_step <= cfg_data[11:0];
        REG_MIN_SPEED:  cfg.min_speed  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_reg.danger_lane0      <= item.danger_lane0;
      in_reg.danger_lane1      <= item.danger_lane1;
      in_reg.danger_lane2      <= item.danger_lane2;
      in_reg.brake_ok          <= item.brake_ok;
      in_reg.now_tick          <= item.now_tick;
      in_reg.recommended_speed <= item.recommended_speed;
    end
  end

  lcd_next u_next (
    .st      (st),
    .item    (in_reg),
    .cfg     (cfg),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode       <= MODE_NORMAL;
      st.lane       <= LANE_MIDDLE;
      st.speed      <= '0;
      st.hold_until <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (fire) st <= st_next;
      if (advance) res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_reg <= st_next;
  end

  assign result.valid          = res_valid;
  assign result.out_mode       = mode_code(res_reg.mode);
  assign result.new_lane       = res_reg.lane;
  assign result.new_speed      = res_reg.speed;
  assign result.out_hold_until = res_reg.hold_until;

`ifndef SYNTHESIS
  a_lane_in_range: assert property (@(posedge clk) disable iff (rst)
    st.lane != 2'd3)
    else $error("target lane left the three-lane range");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |=> $stable(st))
    else $error("state changed while a result was stalled");

  a_lane_change_to_cool: assert property (@(posedge clk) disable iff (rst)
    (fire && st.mode == MODE_LANE) |=> (st.mode == MODE_COOL))
    else $error("lane change mode did not move to cool");

  a_lane_moves_only_on_change: assert property (@(posedge clk) disable iff (rst)
    (fire && st_next.lane != st.lane) |-> (st_next.mode == MODE_LANE))
    else $error("lane changed outside a lane change decision");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    fire |=> (res_reg == st))
    else $error("result register and state disagree after a transfer");
`endif

endmodule

>>> rtl/core/lcd_next.sv
// Next-state logic of the lane change decision block for one control tick.
// Depends on lcd_pkg.
module lcd_next import lcd_pkg::*; (
  input  state_t st,
  input  item_t  item,
  input  cfg_t   cfg,
  output state_t st_next
);

  logic        here;
  logic        lane_ok;
  logic [16:0] ramp_sum;
  logic signed [17:0] brake_diff;
  logic signed [17:0] brake_floor;

  always_comb begin
    unique case (st.lane)
      LANE_LEFT:   here = item.danger_lane0;
      LANE_MIDDLE: here = item.danger_lane1;
      LANE_RIGHT:  here = item.danger_lane2;
      default:     here = 1'b0;
    endcase
  end

  assign lane_ok     = (st.lane != 2'd3);
  assign ramp_sum    = {1'b0, st.speed} + {5'b0, cfg.accel_step};
  assign brake_diff  = $signed({2'b0, st.speed}) - $signed({6'b0, cfg.decel_step});
  assign brake_floor = $signed({2'b0, cfg.min_speed});

  always_comb begin
    st_next = st;
    if (lane_ok) begin
      unique case (st.mode)
        MODE_NORMAL: begin
          st_next.hold_until = '0;
          if (here) begin
            st_next.mode = MODE_DANGER;
          end else if (ramp_sum < {1'b0, item.recommended_speed}) begin
            st_next.speed = ramp_sum[15:0];
          end else begin
            st_next.speed = item.recommended_speed;
          end
        end
        MODE_DANGER: begin
          if (!here) begin
            st_next.mode = MODE_COOL;
          end else if (item.brake_ok) begin
            // The floor may lift the speed when min_speed is above it.
            st_next.speed      = (brake_diff < brake_floor) ? cfg.min_speed
                                                            : brake_diff[15:0];
            st_next.hold_until = item.now_tick + 32'd2;
          end else if (st.lane == LANE_MIDDLE) begin
            if (!item.danger_lane0) begin
              st_next.mode = MODE_LANE;
              st_next.lane = LANE_LEFT;
            end else if (!item.danger_lane2) begin
              st_next.mode = MODE_LANE;
              st_next.lane = LANE_RIGHT;
            end
          end else if (!item.danger_lane1) begin
            st_next.mode = MODE_LANE;
            st_next.lane = LANE_MIDDLE;
          end
        end
        MODE_LANE: begin
          st_next.hold_until = item.now_tick + 32'd1;
          st_next.mode       = MODE_COOL;
        end
        MODE_COOL: begin
          if (item.now_tick > st.hold_until) st_next.mode = MODE_NORMAL;
        end
        default: st_next = st;
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for lane_change_decision_fsm: directed ticks, then random traffic.
// Depends on lcd_pkg, lcd_in_if and lcd_out_if; carries its own model of the decision logic.
module tb_top;
  import lcd_pkg::*;

  localparam int CYCLE_LIMIT = 250000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  lane;
    logic [15:0] speed;
    logic [31:0] hold;
  } decision_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lcd_in_if  item_bus ();
  lcd_out_if result_bus ();

  lane_change_decision_fsm dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_bus),
    .result    (result_bus)
  );

  // Model copy of the registers and the decision state.
  logic [11:0] accel_q;
  logic [11:0] decel_q;
  logic [15:0] floor_q;
  decision_t   model_state;
  decision_t   pending_decisions[$];

  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  logic [31:0] tick_cursor;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned ticks_sent;
  int unsigned results_checked = 0;
  int unsigned settings_used;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles,
               pending_decisions.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("Mismatch in %s at cycle %0d: got %0h, expected %0h", what, cycles, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_result
    decision_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch("unexpected result", {30'b0, result_bus.out_mode}, 32'b0);
      end else begin
        want = pending_decisions.pop_front();
        if (result_bus.out_mode !== want.mode)
          report_mismatch("mode", {30'b0, result_bus.out_mode}, {30'b0, want.mode});
        if (result_bus.new_lane !== want.lane)
          report_mismatch("lane", {30'b0, result_bus.new_lane}, {30'b0, want.lane});
        if (result_bus.new_speed !== want.speed)
          report_mismatch("speed", {16'b0, result_bus.new_speed}, {16'b0, want.speed});
        if (result_bus.out_hold_until !== want.hold)
          report_mismatch("hold tick", result_bus.out_hold_until, want.hold);
        results_checked++;
      end
    end
  end

  // Next decision state for one control tick.
  task automatic advance_decision(input item_t it);
    logic [2:0] danger;
    logic here;
    logic [16:0] ramp;
    logic signed [17:0] braked;
    danger = {it.danger_lane2, it.danger_lane1, it.danger_lane0};
    if (model_state.lane <= LANE_RIGHT) begin
      here = danger[model_state.lane];
      case (model_state.mode)
        CODE_NORMAL: begin
          model_state.hold = '0;
          if (here) begin
            model_state.mode = CODE_DANGER;
          end else begin
            ramp = {1'b0, model_state.speed} + {5'b0, accel_q};
            model_state.speed = (ramp < {1'b0, it.recommended_speed}) ? ramp[15:0]
                                                                       : it.recommended_speed;
          end
        end
        CODE_DANGER: begin
          if (!here) begin
            model_state.mode = CODE_COOL;
          end else if (it.brake_ok) begin
            braked = $signed({2'b0, model_state.speed}) - $signed({6'b0, decel_q});
            if (braked < $signed({2'b0, floor_q})) braked = $signed({2'b0, floor_q});
            model_state.speed = braked[15:0];
            model_state.hold = it.now_tick + 32'd2;
          end else if (model_state.lane == LANE_MIDDLE) begin
            // From the middle lane the left neighbor is tried first.
            if (!danger[LANE_LEFT]) begin
              model_state.mode = CODE_LANE;
              model_state.lane = LANE_LEFT;
            end else if (!danger[LANE_RIGHT]) begin
              model_state.mode = CODE_LANE;
              model_state.lane = LANE_RIGHT;
            end
          end else if (!danger[LANE_MIDDLE]) begin
            model_state.mode = CODE_LANE;
            model_state.lane = LANE_MIDDLE;
          end
        end
        CODE_LANE: begin
          model_state.hold = it.now_tick + 32'd1;
          model_state.mode = CODE_COOL;
        end
        default: begin
          if (it.now_tick > model_state.hold) model_state.mode = CODE_NORMAL;
        end
      endcase
    end
    pending_decisions.push_back(model_state);
  endtask

  // Called at a rising edge; returns at the edge of the transfer with valid still high.
  task automatic send_tick(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid             <= 1'b1;
    item_bus.danger_lane0      <= it.danger_lane0;
    item_bus.danger_lane1      <= it.danger_lane1;
    item_bus.danger_lane2      <= it.danger_lane2;
    item_bus.brake_ok          <= it.brake_ok;
    item_bus.now_tick          <= it.now_tick;
    item_bus.recommended_speed <= it.recommended_speed;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    advance_decision(it);
    ticks_sent++;
  endtask

  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apply_config(input logic [11:0] accel, input logic [11:0] decel,
                              input logic [15:0] floor_speed);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACCEL_STEP;
    cfg_data  <= {4'b0, accel};
    @(posedge clk);
    cfg_index <= REG_DECEL_STEP;
    cfg_data  <= {4'b0, decel};
    @(posedge clk);
    cfg_index <= REG_MIN_SPEED;
    cfg_data  <= floor_speed;
    @(posedge clk);
    cfg_we  <= 1'b0;
    accel_q = accel;
    decel_q = decel;
    floor_q = floor_speed;
    settings_used++;
  endtask

  function automatic item_t tick_item(input logic [2:0] danger, input logic brake,
                                      input logic [31:0] tick, input logic [15:0] rec);
    item_t it;
    it.danger_lane0      = danger[0];
    it.danger_lane1      = danger[1];
    it.danger_lane2      = danger[2];
    it.brake_ok          = brake;
    it.now_tick          = tick;
    it.recommended_speed = rec;
    return it;
  endfunction

  // Mostly a steadily advancing clock with sparse danger; the rest is noise.
  function automatic item_t random_tick_item();
    item_t it;
    it.brake_ok = $urandom_range(99) < 40;
    if ($urandom_range(99) < 85) begin
      tick_cursor = tick_cursor + $urandom_range(2);
      it.danger_lane0 = $urandom_range(99) < 35;
      it.danger_lane1 = $urandom_range(99) < 35;
      it.danger_lane2 = $urandom_range(99) < 35;
      it.recommended_speed = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      tick_cursor = ($urandom_range(3) == 0) ? 32'hFFFF_FFFD : $urandom;
      it.danger_lane0 = 1'($urandom_range(1));
      it.danger_lane1 = 1'($urandom_range(1));
      it.danger_lane2 = 1'($urandom_range(1));
      it.recommended_speed = 16'($urandom);
    end
    it.now_tick = tick_cursor;
    return it;
  endfunction

  task automatic run_random_ticks(input int count);
    repeat (count) send_tick(random_tick_item());
  endtask

  task automatic apply_random_config();
    logic [15:0] floor_speed;
    floor_speed = $urandom_range(1) ? 16'($urandom_range(1023)) : 16'($urandom);
    apply_config(12'($urandom), 12'($urandom), floor_speed);
  endtask

  // Walks every mode transition, both lane choices, tick wrap and the braking floor.
  task automatic test_directed_sequence();
    send_idle_pct  = 29;
    sink_stall_pct = 83;
    send_tick(tick_item(3'b000, 1'b0, 32'd0, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'd1, 16'd10));
    send_tick(tick_item(3'b000, 1'b1, 32'd2, 16'hFFFF));
    send_tick(tick_item(3'b010, 1'b0, 32'd3, 16'hFFFF));
    send_tick(tick_item(3'b010, 1'b1, 32'd4, 16'hFFFF));
    send_tick(tick_item(3'b010, 1'b1, 32'd5, 16'h0000));
    send_tick(tick_item(3'b111, 1'b0, 32'd6, 16'hFFFF));
    send_tick(tick_item(3'b010, 1'b0, 32'd7, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'd8, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'd9, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'd10, 16'hFFFF));
    send_tick(tick_item(3'b001, 1'b0, 32'd11, 16'hFFFF));
    send_tick(tick_item(3'b011, 1'b0, 32'd12, 16'hFFFF));
    send_tick(tick_item(3'b101, 1'b0, 32'd13, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'hFFFF_FFFF, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'd0, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'd1, 16'hFFFF));
    send_tick(tick_item(3'b011, 1'b0, 32'd2, 16'hFFFF));
    send_tick(tick_item(3'b011, 1'b0, 32'd3, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'd4, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'd6, 16'hFFFF));
    send_tick(tick_item(3'b100, 1'b0, 32'd7, 16'hFFFF));
    send_tick(tick_item(3'b110, 1'b1, 32'hFFFF_FFFE, 16'hFFFF));
    send_tick(tick_item(3'b010, 1'b0, 32'hFFFF_FFFF, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'd1, 16'hFFFF));
    send_tick(tick_item(3'b000, 1'b0, 32'd2, 16'h0000));
    wait_idle();
  endtask

  task automatic test_extreme_steps();
    send_idle_pct  = 29;
    sink_stall_pct = 83;
    apply_config(12'hFFF, 12'hFFF, 16'hFFFF);
    run_random_ticks(150);
    wait_idle();
  endtask

  task automatic test_zero_steps();
    send_idle_pct  = 83;
    sink_stall_pct = 29;
    apply_config(12'h000, 12'h000, 16'h0000);
    run_random_ticks(125);
    wait_idle();
  endtask

  task automatic test_random_steps();
    send_idle_pct  = 83;
    sink_stall_pct = 29;
    repeat (3) begin
      apply_random_config();
      run_random_ticks(50);
      wait_idle();
    end
  endtask

  task automatic test_back_to_back();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    repeat (2) begin
      apply_random_config();
      run_random_ticks(100);
      wait_idle();
    end
  endtask

  initial begin
    ticks_sent      = 0;
    settings_used   = 1;
    send_idle_pct   = 0;
    sink_stall_pct  = 0;
    tick_cursor     = 32'd100;
    accel_q = ACCEL_STEP_RST;
    decel_q = DECEL_STEP_RST;
    floor_q = MIN_SPEED_RST;
    model_state = '{mode: CODE_NORMAL, lane: LANE_MIDDLE, speed: 16'd0, hold: 32'd0};

    rst                        <= 1'b1;
    cfg_we                     <= 1'b0;
    cfg_index                  <= REG_ACCEL_STEP;
    cfg_data                   <= '0;
    item_bus.valid             <= 1'b0;
    item_bus.danger_lane0      <= 1'b0;
    item_bus.danger_lane1      <= 1'b0;
    item_bus.danger_lane2      <= 1'b0;
    item_bus.brake_ok          <= 1'b0;
    item_bus.now_tick          <= '0;
    item_bus.recommended_speed <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_sequence();
    test_extreme_steps();
    test_zero_steps();
    test_random_steps();
    test_back_to_back();

    $display("Sent %0d control ticks under %0d register settings; %0d decisions checked.",
             ticks_sent, settings_used, results_checked);
    $display("Stall patterns: slow receiver, slow sender, then full rate; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
